/* hw/rtl/hts_pkg.sv */
package hts_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int TEMP_W      = 12;
  localparam int THR_W       = 6;
  localparam int FILT_W      = 4;
  localparam int STREAK_W    = 8;
  localparam int COUNT_W     = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AUTO_ENABLE   = 2'd0,
    CFG_ON_THRESHOLD  = 2'd1,
    CFG_OFF_THRESHOLD = 2'd2,
    CFG_FILT_LEN      = 2'd3
  } cfg_index_t;

  localparam logic              RST_AUTO_ENABLE   = 1'b0;
  localparam logic [THR_W-1:0]  RST_ON_THRESHOLD  = 6'd28;
  localparam logic [THR_W-1:0]  RST_OFF_THRESHOLD = 6'd26;
  localparam logic [FILT_W-1:0] RST_FILT_LEN      = 4'd3;

  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic              auto_enable;
    logic [THR_W-1:0]  on_threshold;
    logic [THR_W-1:0]  off_threshold;
    logic [FILT_W-1:0] filt_len;
  } cfg_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic                     tx_ok;
  } item_t;

  typedef struct packed {
    logic                send_valid;
    logic                send_power;
    logic                power_state;
    logic [COUNT_W-1:0]  on_total;
    logic [COUNT_W-1:0]  off_total;
    logic [STREAK_W-1:0] streak_shown;
  } result_t;

  // whole degrees to tenths, as a signed value wide enough to compare with a sample
  function automatic logic signed [TEMP_W:0] to_tenths(input logic [THR_W-1:0] thr);
    logic [TEMP_W:0] x;
    x = TEMP_W'(thr) * (TEMP_W+1)'(10);
    return $signed(x);
  endfunction

  function automatic logic [STREAK_W-1:0] sat_inc(input logic [STREAK_W-1:0] v);
    return (v == STREAK_MAX) ? STREAK_MAX : v + STREAK_W'(1);
  endfunction

endpackage

/* hw/rtl/hts_ifs.sv */
interface hts_sample_if;
  import hts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic                     tx_ok;

  modport source(output valid, cmd, temp_tenths, tx_ok, input ready);
  modport sink(input valid, cmd, temp_tenths, tx_ok, output ready);
endinterface

interface hts_result_if;
  import hts_pkg::*;
  logic                valid;
  logic                ready;
  logic                send_valid;
  logic                send_power;
  logic                power_state;
  logic [COUNT_W-1:0]  on_total;
  logic [COUNT_W-1:0]  off_total;
  logic [STREAK_W-1:0] streak_shown;

  modport source(output valid, send_valid, send_power, power_state, on_total, off_total,
                 streak_shown, input ready);
  modport sink(input valid, send_valid, send_power, power_state, on_total, off_total,
               streak_shown, output ready);
endinterface

/* hw/rtl/hts_cfg_regs.sv */
module hts_cfg_regs
  import hts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_enable   <= RST_AUTO_ENABLE;
      cfg.on_threshold  <= RST_ON_THRESHOLD;
      cfg.off_threshold <= RST_OFF_THRESHOLD;
      cfg.filt_len      <= RST_FILT_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_AUTO_ENABLE:   cfg.auto_enable   <= cfg_data[0];
        CFG_ON_THRESHOLD:  cfg.on_threshold  <= cfg_data[THR_W-1:0];
        CFG_OFF_THRESHOLD: cfg.off_threshold <= cfg_data[THR_W-1:0];
        CFG_FILT_LEN:      cfg.filt_len      <= cfg_data[FILT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/hts_in_reg.sv */
module hts_in_reg
  import hts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  hts_sample_if.sink   sample,
  input  logic         take,
  output logic         item_valid,
  output item_t        item
);

  // no word is taken while reset is held
  assign sample.ready = !rst && (!item_valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample.ready) begin
      item_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      item.cmd         <= sample.cmd;
      item.temp_tenths <= sample.temp_tenths;
      item.tx_ok       <= sample.tx_ok;
    end
  end

endmodule

/* hw/rtl/hts_core.sv */
module hts_core
  import hts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         item_valid,
  input  item_t        item,
  output logic         take,
  hts_result_if.source result
);

  logic [STREAK_W-1:0] on_streak, on_streak_next;
  logic [STREAK_W-1:0] off_streak, off_streak_next;
  logic                power_on, power_on_next;
  logic [COUNT_W-1:0]  on_counter, on_counter_next;
  logic [COUNT_W-1:0]  off_counter, off_counter_next;
  logic                res_valid;
  result_t             res, res_next;

  logic [FILT_W-1:0]        need;
  logic signed [TEMP_W:0]   temp_x;
  logic signed [TEMP_W:0]   on_lim, off_lim;
  logic [STREAK_W-1:0]      on_inc, off_inc;

  assign take = item_valid && (!res_valid || result.ready);

  assign need    = (cfg.filt_len == '0) ? FILT_W'(1) : cfg.filt_len;
  assign temp_x  = (TEMP_W+1)'(item.temp_tenths);
  assign on_lim  = to_tenths(cfg.on_threshold);
  assign off_lim = to_tenths(cfg.off_threshold);
  assign on_inc  = sat_inc(on_streak);
  assign off_inc = sat_inc(off_streak);

  always_comb begin
    on_streak_next   = on_streak;
    off_streak_next  = off_streak;
    power_on_next    = power_on;
    on_counter_next  = on_counter;
    off_counter_next = off_counter;
    res_next.send_valid = 1'b0;
    res_next.send_power = 1'b0;

    if (item.cmd == CMD_CLEAR) begin
      on_streak_next   = '0;
      off_streak_next  = '0;
      on_counter_next  = '0;
      off_counter_next = '0;
    end else if (cfg.auto_enable) begin
      // on side wins when the thresholds overlap
      priority if (temp_x > on_lim) begin
        on_streak_next  = on_inc;
        off_streak_next = '0;
        if (on_inc >= STREAK_W'(need) && !power_on) begin
          res_next.send_valid = 1'b1;
          res_next.send_power = 1'b1;
          on_streak_next      = '0;
          if (item.tx_ok) begin
            power_on_next   = 1'b1;
            on_counter_next = on_counter + COUNT_W'(1);
          end
        end
      end else if (temp_x < off_lim) begin
        off_streak_next = off_inc;
        on_streak_next  = '0;
        if (off_inc >= STREAK_W'(need) && power_on) begin
          res_next.send_valid = 1'b1;
          off_streak_next     = '0;
          if (item.tx_ok) begin
            power_on_next    = 1'b0;
            off_counter_next = off_counter + COUNT_W'(1);
          end
        end
      end else begin
        on_streak_next  = '0;
        off_streak_next = '0;
      end
    end

    res_next.power_state  = power_on_next;
    res_next.on_total     = on_counter_next;
    res_next.off_total    = off_counter_next;
    res_next.streak_shown = (on_streak_next > off_streak_next) ? on_streak_next
                                                                : off_streak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_streak   <= '0;
      off_streak  <= '0;
      power_on    <= 1'b0;
      on_counter  <= '0;
      off_counter <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (take) begin
        on_streak   <= on_streak_next;
        off_streak  <= off_streak_next;
        power_on    <= power_on_next;
        on_counter  <= on_counter_next;
        off_counter <= off_counter_next;
        res_valid   <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.send_valid   = res.send_valid;
  assign result.send_power   = res.send_power;
  assign result.power_state  = res.power_state;
  assign result.on_total     = res.on_total;
  assign result.off_total    = res.off_total;
  assign result.streak_shown = res.streak_shown;

endmodule

/* hw/rtl/hysteresis_thermostat_filtered.sv */
// An accepted sample word passes through the input register, then the result register,
// before its result word appears. One word per cycle while result.ready is held; the
// streak and counter update is combinational logic ahead of the result register.
// Reset (rst, synchronous): streaks, counters and power state clear, registers take
// auto_enable 0, on 28, off 26, filter 3; no word is held in either stage.
module hysteresis_thermostat_filtered
  import hts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  hts_sample_if.sink             sample,
  hts_result_if.source           result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  take;
  logic  item_valid;
  item_t item;

  hts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hts_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  hts_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .result     (result)
  );

endmodule
